/* hdl/brd_pkg.sv */
// Package for the backup record deframer: item and result types, result kinds,
// register indexes and reset values. Used by every file in hdl; depends on nothing.

package brd_pkg;

    localparam int LONG_HEADER_BYTES  = 20;
    localparam int SHORT_HEADER_BYTES = 12;
    localparam int LENGTH_BITS        = 24;

    // Result queue depth; must be a power of two and at least two.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_HEADER           = 3'd0;
    localparam logic [2:0] KIND_DATA             = 3'd1;
    localparam logic [2:0] KIND_SESSION_MISMATCH = 3'd2;
    localparam logic [2:0] KIND_STREAM_MISMATCH  = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG         = 3'd4;
    localparam logic [2:0] KIND_BLOCK_EXHAUSTED  = 3'd5;

    localparam logic ACTION_BEGIN = 1'b0;
    localparam logic ACTION_BYTE  = 1'b1;

    // Block format that carries long record headers; any other uses short ones.
    localparam logic [7:0] BLOCK_VERSION_LONG = 8'd1;

    localparam logic CFG_STREAM_TYPE_MASK  = 1'b0;
    localparam logic CFG_MAX_RECORD_LENGTH = 1'b1;

    localparam logic [30:0] STREAM_MASK_RESET = 31'd2047;
    localparam logic [23:0] MAX_LENGTH_RESET  = 24'd4000000;

    typedef struct packed {
        logic        action;
        logic [23:0] block_length;
        logic [7:0]  block_version;
        logic [31:0] block_session_id;
        logic [31:0] block_session_time;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] file_index;
        logic [30:0]        stream;
        logic [30:0]        masked_stream;
        logic [31:0]        session_id;
        logic [31:0]        session_time;
        logic [23:0]        record_length;
        logic               continuation;
        logic [7:0]         payload_byte;
        logic               last_of_record;
        logic               partial;
    } out_item_t;

    // Results written into the queue in one cycle: second only with first.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

/* hdl/backup_record_deframer.sv */
// Top level of the backup record deframer: input register, header and data
// parsing, configuration registers. Depends on brd_pkg and brd_result_queue.
//
// Path: input register, then result queue, from which the first result is taken.
// Throughput: one item per cycle while the queue has room for two; one result leaves
// per cycle unless stalled; the four-entry queue absorbs items that cause two results.
// Reset: clears the parse state, sets the registers to their defaults; no clearing pass.

module backup_record_deframer #(
    parameter int LENGTH_BITS = brd_pkg::LENGTH_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  brd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output brd_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int LB     = LENGTH_BITS;
    localparam int HMAX   = brd_pkg::LONG_HEADER_BYTES;
    localparam int HCW    = $clog2(HMAX + 1);
    localparam int HIW    = $clog2(HMAX);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Input register.
    logic              item_vld_reg, item_vld_next;
    brd_pkg::in_item_t item_reg;
    logic              accept, process, room;

    // Parse state.
    logic [1:0]     phase_reg, phase_next;
    logic [HCW-1:0] hcount_reg, hcount_next;
    logic [7:0]     hbytes_reg [HMAX];
    logic [LB-1:0]  bleft_reg, bleft_next;
    logic [LB-1:0]  dleft_reg, dleft_next;
    logic           rpend_reg, rpend_next;
    logic [31:0]    sv_sid_reg, sv_sid_next;
    logic [31:0]    sv_stime_reg, sv_stime_next;
    logic [30:0]    sv_stream_reg, sv_stream_next;
    logic           long_reg, long_next;
    logic [31:0]    blk_sid_reg, blk_sid_next;
    logic [31:0]    blk_stime_reg, blk_stime_next;

    logic [30:0] mask_reg;
    logic [23:0] maxlen_reg;

    // Header decode.
    logic [7:0]     hv [HMAX];
    logic [31:0]    w [5];
    logic [31:0]    sid, stime, fi, sraw, len, mag;
    logic [30:0]    strm;
    logic           cont;
    logic [HCW-1:0] hcount_inc, hl_cur, hl_next;
    logic           hb_we;

    logic               chk;
    logic [LB-1:0]      chk_left;
    logic               first_used;
    brd_pkg::push_t     push;
    brd_pkg::out_item_t res0, res1;

    function automatic brd_pkg::out_item_t status_item(input logic [2:0] kind);
        brd_pkg::out_item_t r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

    assign in_stall  = item_vld_reg && !process;
    assign accept    = in_valid && !in_stall;
    assign process   = item_vld_reg && room;
    assign cfg_ready = 1'b1;

    assign hcount_inc = hcount_reg + HCW'(1);
    assign hl_cur  = long_reg ? HCW'(brd_pkg::LONG_HEADER_BYTES)
                              : HCW'(brd_pkg::SHORT_HEADER_BYTES);
    assign hl_next = long_next ? HCW'(brd_pkg::LONG_HEADER_BYTES)
                               : HCW'(brd_pkg::SHORT_HEADER_BYTES);

    // The header as it stands with the current byte placed.
    always_comb
    begin
        for (int k = 0; k < HMAX; k++)
        begin
            hv[k] = (hcount_reg == HCW'(k)) ? item_reg.data_byte : hbytes_reg[k];
        end
        for (int i = 0; i < 5; i++)
        begin
            w[i] = {hv[4*i], hv[4*i+1], hv[4*i+2], hv[4*i+3]};
        end
        if (long_reg)
        begin
            sid   = w[0];
            stime = w[1];
            fi    = w[2];
            sraw  = w[3];
            len   = w[4];
        end
        else
        begin
            sid   = blk_sid_reg;
            stime = blk_stime_reg;
            fi    = w[0];
            sraw  = w[1];
            len   = w[2];
        end
        cont = sraw[31];
        mag  = 32'd0 - sraw;
        strm = cont ? mag[30:0] : sraw[30:0];
    end

    always_comb
    begin
        item_vld_next  = accept ? 1'b1 : (process ? 1'b0 : item_vld_reg);
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        bleft_next     = bleft_reg;
        dleft_next     = dleft_reg;
        rpend_next     = rpend_reg;
        sv_sid_next    = sv_sid_reg;
        sv_stime_next  = sv_stime_reg;
        sv_stream_next = sv_stream_reg;
        long_next      = long_reg;
        blk_sid_next   = blk_sid_reg;
        blk_stime_next = blk_stime_reg;
        hb_we          = 1'b0;
        chk            = 1'b0;
        chk_left       = bleft_reg;
        first_used     = 1'b0;
        res0           = '0;
        res1           = '0;
        push           = '0;

        if (process)
        begin
            if (item_reg.action == brd_pkg::ACTION_BEGIN)
            begin
                bleft_next     = LB'(item_reg.block_length);
                long_next      = (item_reg.block_version == brd_pkg::BLOCK_VERSION_LONG);
                blk_sid_next   = item_reg.block_session_id;
                blk_stime_next = item_reg.block_session_time;
                dleft_next     = '0;
                chk            = 1'b1;
                chk_left       = LB'(item_reg.block_length);
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        if (bleft_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            hb_we       = (hcount_reg < HCW'(HMAX));
                            hcount_next = hcount_inc;
                            bleft_next  = bleft_reg - LB'(1);
                            if (hcount_inc >= hl_cur)
                            begin
                                hcount_next = '0;
                                first_used  = 1'b1;
                                push.first  = 1'b1;
                                if (rpend_reg &&
                                    (sv_sid_reg != sid || sv_stime_reg != stime))
                                begin
                                    res0       = status_item(brd_pkg::KIND_SESSION_MISMATCH);
                                    phase_next = PH_IDLE;
                                end
                                else if (cont && rpend_reg && {1'b0, sv_stream_reg} != mag)
                                begin
                                    res0       = status_item(brd_pkg::KIND_STREAM_MISMATCH);
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    sv_stream_next = strm;
                                    sv_sid_next    = sid;
                                    sv_stime_next  = stime;
                                    if (len >= {8'd0, maxlen_reg})
                                    begin
                                        res0       = status_item(brd_pkg::KIND_TOO_LONG);
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        res0.kind          = brd_pkg::KIND_HEADER;
                                        res0.file_index    = fi;
                                        res0.stream        = strm;
                                        res0.masked_stream = strm & mask_reg;
                                        res0.session_id    = sid;
                                        res0.session_time  = stime;
                                        res0.record_length = len[23:0];
                                        res0.continuation  = cont;
                                        dleft_next         = LB'(len);
                                        chk_left           = bleft_next;
                                        if (LB'(len) == '0)
                                        begin
                                            rpend_next = 1'b0;
                                            chk        = 1'b1;
                                        end
                                        else if (bleft_next == '0)
                                        begin
                                            rpend_next = 1'b1;
                                            chk        = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_DATA;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (bleft_reg == '0 || dleft_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            bleft_next          = bleft_reg - LB'(1);
                            dleft_next          = dleft_reg - LB'(1);
                            first_used          = 1'b1;
                            push.first          = 1'b1;
                            res0.kind           = brd_pkg::KIND_DATA;
                            res0.payload_byte   = item_reg.data_byte;
                            res0.last_of_record = (dleft_next == '0);
                            res0.partial        = (dleft_next != '0) && (bleft_next == '0);
                            chk_left            = bleft_next;
                            if (res0.last_of_record)
                            begin
                                rpend_next = 1'b0;
                                chk        = 1'b1;
                            end
                            else if (res0.partial)
                            begin
                                rpend_next = 1'b1;
                                chk        = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // Bytes while idle are dropped.
                    end
                endcase
            end

            // Either the block is exhausted or the next header begins.
            if (chk)
            begin
                hcount_next = '0;
                if (chk_left < LB'(hl_next))
                begin
                    phase_next = PH_IDLE;
                    if (first_used)
                    begin
                        res1        = status_item(brd_pkg::KIND_BLOCK_EXHAUSTED);
                        push.second = 1'b1;
                    end
                    else
                    begin
                        res0       = status_item(brd_pkg::KIND_BLOCK_EXHAUSTED);
                        push.first = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_HEAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            hcount_reg    <= '0;
            bleft_reg     <= '0;
            dleft_reg     <= '0;
            rpend_reg     <= 1'b0;
            sv_sid_reg    <= '0;
            sv_stime_reg  <= '0;
            sv_stream_reg <= '0;
            long_reg      <= 1'b0;
            blk_sid_reg   <= '0;
            blk_stime_reg <= '0;
            mask_reg      <= brd_pkg::STREAM_MASK_RESET;
            maxlen_reg    <= brd_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            item_vld_reg  <= item_vld_next;
            phase_reg     <= phase_next;
            hcount_reg    <= hcount_next;
            bleft_reg     <= bleft_next;
            dleft_reg     <= dleft_next;
            rpend_reg     <= rpend_next;
            sv_sid_reg    <= sv_sid_next;
            sv_stime_reg  <= sv_stime_next;
            sv_stream_reg <= sv_stream_next;
            long_reg      <= long_next;
            blk_sid_reg   <= blk_sid_next;
            blk_stime_reg <= blk_stime_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    brd_pkg::CFG_STREAM_TYPE_MASK:  mask_reg   <= cfg_data[30:0];
                    brd_pkg::CFG_MAX_RECORD_LENGTH: maxlen_reg <= cfg_data[23:0];
                    default:                        mask_reg   <= mask_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (hb_we)
        begin
            hbytes_reg[hcount_reg[HIW-1:0]] <= item_reg.data_byte;
        end
    end

    brd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data0     (res0),
        .data1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    a_data_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (dleft_reg != '0 && bleft_reg != '0))
        else $error("data phase with nothing left to carry");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEAD) |-> (hcount_reg < hl_cur))
        else $error("header count past header length");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (hcount_reg == '0))
        else $error("header count not cleared while idle");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && !room) |=> item_vld_reg)
        else $error("held item lost while the queue was full");

endmodule

/* hdl/brd_result_queue.sv */
// Small result queue for the backup record deframer: takes up to two results
// a cycle and hands out one while out_stall is low. Depends on brd_pkg.

module brd_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  brd_pkg::push_t    push,
    input  brd_pkg::out_item_t data0,
    input  brd_pkg::out_item_t data1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output brd_pkg::out_item_t out_item
);

    localparam int DEPTH = brd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    brd_pkg::out_item_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;
    logic [1:0]    n_push;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    // Room for two results, so any item can be processed.
    assign room      = (cnt_reg <= CW'(DEPTH - 2));
    assign n_push    = 2'(push.first) + 2'(push.second);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + CW'(n_push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[wr_ptr_reg] <= data0;
        end
        if (push.second)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= data1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second result pushed without a first");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push.first && !out_valid) |=> out_valid)
        else $error("pushed result did not appear at the output");

endmodule
